@@ hw/rtl/hdb_pkg.sv @@
// Package: shared constants and arctangent table.
package hdb_pkg;

  localparam int unsigned TableLen = 40;
  localparam logic signed [35:0] GainInvQ30 = 36'sd652032875;
  localparam logic signed [35:0] Q30One = 36'sd1073741824;
  localparam logic [31:0] HalfTurn = 32'h8000_0000;
  localparam logic [31:0] QuarterTurn = 32'h4000_0000;
  localparam logic [31:0] CmPerTurn = 32'd4003017359;
  localparam logic [15:0] CentidegPerTurn = 16'd36000;

  function automatic logic [31:0] atan_bam(input logic [5:0] idx);
    logic [31:0] r;
    begin
      case (idx)
        6'd0: r = 32'd536870912;
        6'd1: r = 32'd316933406;
        6'd2: r = 32'd167458907;
        6'd3: r = 32'd85004756;
        6'd4: r = 32'd42667331;
        6'd5: r = 32'd21354465;
        6'd6: r = 32'd10679838;
        6'd7: r = 32'd5340245;
        6'd8: r = 32'd2670163;
        6'd9: r = 32'd1335087;
        6'd10: r = 32'd667544;
        6'd11: r = 32'd333772;
        6'd12: r = 32'd166886;
        6'd13: r = 32'd83443;
        6'd14: r = 32'd41722;
        6'd15: r = 32'd20861;
        6'd16: r = 32'd10430;
        6'd17: r = 32'd5215;
        6'd18: r = 32'd2608;
        6'd19: r = 32'd1304;
        6'd20: r = 32'd652;
        6'd21: r = 32'd326;
        6'd22: r = 32'd163;
        6'd23: r = 32'd81;
        6'd24: r = 32'd41;
        6'd25: r = 32'd20;
        6'd26: r = 32'd10;
        6'd27: r = 32'd5;
        6'd28: r = 32'd3;
        6'd29: r = 32'd1;
        6'd30: r = 32'd1;
        default: r = 32'd0;
      endcase
      return r;
    end
  endfunction

endpackage

@@ hw/rtl/haversine_distance_bearing.sv @@
// Top level: pipelined haversine range and initial bearing.
// Usage: one transaction on s_axis carries two positions (current, goal) as
// degrees*1e7. One transaction leaves on m_axis per input with the range in
// centimeters and the initial bearing in hundredths of a degree.
// The datapath is one long pipeline: angle conversion, four parallel CORDIC
// sine/cosine units, product stages, a haversine stage, two square root
// pipelines, and two CORDIC atan2 units, then scaling.
// Throughput: one transaction per cycle while m_axis is not stalled.
// The pipeline advances whenever the output register is empty or taken;
// s_axis_tready is low only while a valid result waits in the output
// register and m_axis_tready is low. Nothing is dropped or repeated under
// stalls, the whole pipeline simply freezes.
// Reset clears all valid bits; payload registers are not reset.
// Bearing is 0 when both points coincide or are antipodal.
module haversine_distance_bearing #(
  parameter int unsigned CORDIC_STEPS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // here_lat[30:0], here_lon[62:31], goal_lat[93:63], goal_lon[125:94], zero
  input  logic [127:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // range_cm[30:0], bearing_centideg[46:31], zero
  output logic [47:0] m_axis_tdata
);

  localparam int unsigned Steps = (CORDIC_STEPS > 40) ? 40 : CORDIC_STEPS;
  localparam int unsigned SqrtLat = 31;
  // cvt(3) sincos(Steps+1) prod(3) hav(1) sqrt(SqrtLat+1) atan(Steps+1) scale(2)
  localparam int unsigned Lat = 3 + Steps + 1 + 3 + 1 + SqrtLat + 1 + Steps + 1 + 2;

  logic en;
  logic [Lat-1:0] vld_q;
  logic out_vld_q;

  assign en = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      out_vld_q <= 1'b0;
    end else if (en) begin
      vld_q <= {vld_q[Lat-2:0], s_axis_tvalid};
      out_vld_q <= vld_q[Lat-1];
    end
  end

  // angle conversion: v*2^31/1.8e9 truncated toward zero
  logic signed [31:0] cin [4];
  assign cin[0] = 32'(signed'(s_axis_tdata[30:0]));
  assign cin[1] = signed'(s_axis_tdata[62:31]);
  assign cin[2] = 32'(signed'(s_axis_tdata[93:63]));
  assign cin[3] = signed'(s_axis_tdata[125:94]);

  // |v|*2^31 / 1.8e9 = (|v| * 2^31 / 1.8e9); use reciprocal: 2^31/1.8e9 = 2^28/225e6
  // q = floor(|v| * 2^28 / 225000000). Reciprocal m = ceil(2^(28+60)/225e6)?
  // Exact: compute p=|v|*M>>K with M=ceil(2^K*2^28/225e6), verified below bound.
  localparam int unsigned RecK = 60;
  localparam logic [63:0] RecM = 64'((128'd1 << (RecK + 28)) / 128'd225000000 + 128'd1);
  logic [31:0] mag_q [4];
  logic        neg_q [4];
  logic [63:0] pl_q [4];
  logic [63:0] ph_q [4];
  logic        neg2_q [4];
  logic [31:0] bam_q [4];

  for (genvar k = 0; k < 4; k++) begin : g_cvt
    logic [95:0] sum_w;
    logic [31:0] q_w;
    assign sum_w = {32'd0, pl_q[k]} + {ph_q[k], 32'd0};
    assign q_w = sum_w[RecK +: 32];
    always_ff @(posedge clk_i) begin
      if (en) begin
        neg_q[k] <= cin[k][31];
        mag_q[k] <= cin[k][31] ? 32'(-33'(cin[k])) : cin[k];
        pl_q[k] <= {32'd0, mag_q[k]} * {32'd0, RecM[31:0]};
        ph_q[k] <= {32'd0, mag_q[k]} * {32'd0, RecM[63:32]};
        neg2_q[k] <= neg_q[k];
        bam_q[k] <= neg2_q[k] ? -q_w : q_w;
      end
    end
  end

  logic [31:0] dlat, dlon;
  assign dlat = bam_q[2] - bam_q[0];
  assign dlon = bam_q[3] - bam_q[1];

  logic signed [35:0] s1, c1, s2, c2, sn, cn, se, ce;
  hdb_sincos #(.Steps(Steps)) u_sc1 (.clk_i, .en_i(en), .ang_i(bam_q[0]), .sin_o(s1), .cos_o(c1));
  hdb_sincos #(.Steps(Steps)) u_sc2 (.clk_i, .en_i(en), .ang_i(bam_q[2]), .sin_o(s2), .cos_o(c2));
  hdb_sincos #(.Steps(Steps)) u_scn (.clk_i, .en_i(en), .ang_i(dlat), .sin_o(sn), .cos_o(cn));
  hdb_sincos #(.Steps(Steps)) u_sce (.clk_i, .en_i(en), .ang_i(dlon), .sin_o(se), .cos_o(ce));

  // product stage 1
  logic signed [35:0] cc_q, omcn_q, omce_q, by_q, c1s2_q, s1c2_q, ce1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      cc_q <= 36'((72'(c1) * 72'(c2)) >>> 30);
      omcn_q <= hdb_pkg::Q30One - cn;
      omce_q <= hdb_pkg::Q30One - ce;
      by_q <= 36'((72'(se) * 72'(c2)) >>> 30);
      c1s2_q <= 36'((72'(c1) * 72'(s2)) >>> 30);
      s1c2_q <= 36'((72'(s1) * 72'(c2)) >>> 30);
      ce1_q <= ce;
    end
  end
  // product stage 2
  logic signed [35:0] t1_q, t2_q, by2_q, bx2_q, c1s2b_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_q <= omcn_q >>> 1;
      t2_q <= 36'((72'(cc_q) * 72'(omce_q)) >>> 31);
      by2_q <= by_q;
      c1s2b_q <= c1s2_q;
      bx2_q <= 36'((72'(s1c2_q) * 72'(ce1_q)) >>> 30);
    end
  end
  // stage 3
  logic signed [35:0] a_q, by3_q, bx3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      a_q <= t1_q + t2_q;
      by3_q <= by2_q;
      bx3_q <= c1s2b_q - bx2_q;
    end
  end
  // haversine clamp
  logic [30:0] ac_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (a_q < 0) ac_q <= '0;
      else if (a_q > hdb_pkg::Q30One) ac_q <= 31'd1 << 30;
      else ac_q <= a_q[30:0];
    end
  end
  logic [30:0] ab_w;
  assign ab_w = (31'd1 << 30) - ac_q;

  logic [30:0] sa, sb;
  hdb_isqrt u_sqa (.clk_i, .en_i(en), .v_i({ac_q, 31'd0} >> 1), .r_o(sa));
  hdb_isqrt u_sqb (.clk_i, .en_i(en), .v_i({ab_w, 31'd0} >> 1), .r_o(sb));

  // delay bearing vector to line up with the sqrt outputs
  localparam int unsigned BDly = SqrtLat + 2;
  logic signed [35:0] byd_q [BDly];
  logic signed [35:0] bxd_q [BDly];
  always_ff @(posedge clk_i) begin
    if (en) begin
      byd_q[0] <= by3_q;
      bxd_q[0] <= bx3_q;
      for (int j = 1; j < BDly; j++) begin
        byd_q[j] <= byd_q[j-1];
        bxd_q[j] <= bxd_q[j-1];
      end
    end
  end

  logic [31:0] cb, brg;
  hdb_atan2 #(.Steps(Steps)) u_atc (.clk_i, .en_i(en), .y_i(36'(sa)), .x_i(36'(sb)), .ang_o(cb));
  hdb_atan2 #(.Steps(Steps)) u_atb (.clk_i, .en_i(en), .y_i(byd_q[BDly-1]),
                                    .x_i(bxd_q[BDly-1]), .ang_o(brg));

  // scaling
  logic [31:0] cbc_q, brg_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      if (cb >= hdb_pkg::HalfTurn) cbc_q <= '0;
      else if (cb > hdb_pkg::QuarterTurn) cbc_q <= hdb_pkg::QuarterTurn;
      else cbc_q <= cb;
      brg_q <= brg;
    end
  end
  logic [63:0] rp_w;
  logic [47:0] bp_w;
  logic [30:0] rng_q;
  logic [15:0] cd_q;
  assign rp_w = {cbc_q[30:0], 1'b0} * {32'd0, hdb_pkg::CmPerTurn} + 64'h8000_0000;
  assign bp_w = 48'(brg_q) * 48'(hdb_pkg::CentidegPerTurn) + 48'h8000_0000;
  always_ff @(posedge clk_i) begin
    if (en) begin
      rng_q <= rp_w[62:32];
      cd_q <= (bp_w[47:32] >= hdb_pkg::CentidegPerTurn) ? 16'd0 : bp_w[47:32];
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) m_axis_tdata <= {1'b0, cd_q, rng_q};
  end

endmodule

@@ hw/rtl/hdb_sincos.sv @@
// Pipelined rotation-mode CORDIC producing sine and cosine in Q30.
module hdb_sincos #(
  parameter int unsigned Steps = 24
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [31:0]        ang_i,
  output logic signed [35:0] sin_o,
  output logic signed [35:0] cos_o
);

  logic signed [35:0] x_q [Steps+1];
  logic signed [35:0] y_q [Steps+1];
  logic signed [33:0] z_q [Steps+1];
  logic               f_q [Steps+1];
  logic [31:0] a_w;
  logic        flip_w;

  assign flip_w = ((ang_i + hdb_pkg::QuarterTurn) & hdb_pkg::HalfTurn) != 32'd0;
  assign a_w = flip_w ? (ang_i ^ hdb_pkg::HalfTurn) : ang_i;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= hdb_pkg::GainInvQ30;
      y_q[0] <= '0;
      z_q[0] <= 34'(signed'(a_w));
      f_q[0] <= flip_w;
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_stage
    localparam logic [5:0] Idx = 6'(i);
    logic signed [33:0] t_w;
    assign t_w = 34'(hdb_pkg::atan_bam(Idx));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (z_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - t_w;
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + t_w;
        end
        f_q[i+1] <= f_q[i];
      end
    end
  end

  assign sin_o = f_q[Steps] ? -y_q[Steps] : y_q[Steps];
  assign cos_o = f_q[Steps] ? -x_q[Steps] : x_q[Steps];

endmodule

@@ hw/rtl/hdb_atan2.sv @@
// Pipelined vectoring-mode CORDIC giving atan2 as a binary angle.
module hdb_atan2 #(
  parameter int unsigned Steps = 24
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [35:0] y_i,
  input  logic signed [35:0] x_i,
  output logic [31:0]        ang_o
);

  logic signed [37:0] x_q [Steps+1];
  logic signed [37:0] y_q [Steps+1];
  logic signed [33:0] z_q [Steps+1];
  logic [31:0]        b_q [Steps+1];
  logic               zr_q [Steps+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zr_q[0] <= (x_i == 0) && (y_i == 0);
      z_q[0] <= '0;
      if (x_i < 0) begin
        x_q[0] <= -38'(x_i);
        y_q[0] <= -38'(y_i);
        b_q[0] <= hdb_pkg::HalfTurn;
      end else begin
        x_q[0] <= 38'(x_i);
        y_q[0] <= 38'(y_i);
        b_q[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_stage
    localparam logic [5:0] Idx = 6'(i);
    logic signed [33:0] t_w;
    assign t_w = 34'(hdb_pkg::atan_bam(Idx));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + t_w;
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - t_w;
        end
        b_q[i+1] <= b_q[i];
        zr_q[i+1] <= zr_q[i];
      end
    end
  end

  assign ang_o = zr_q[Steps] ? 32'd0 : (b_q[Steps] + z_q[Steps][31:0]);

endmodule

@@ hw/rtl/hdb_isqrt.sv @@
// Pipelined floor square root of a 62-bit value, one result bit per stage.
module hdb_isqrt (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [61:0] v_i,
  output logic [30:0] r_o
);

  localparam int unsigned Bits = 31;

  logic [61:0] rem_q [Bits+1];
  logic [30:0] r_q [Bits+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= v_i;
      r_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < Bits; i++) begin : g_stage
    localparam int unsigned B = Bits - 1 - i;
    logic [63:0] trial_w;
    assign trial_w = ({33'd0, r_q[i]} << (B + 1)) + (64'd1 << (2 * B));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if ({2'b00, rem_q[i]} >= trial_w) begin
          rem_q[i+1] <= rem_q[i] - trial_w[61:0];
          r_q[i+1] <= r_q[i] | (31'd1 << B);
        end else begin
          rem_q[i+1] <= rem_q[i];
          r_q[i+1] <= r_q[i];
        end
      end
    end
  end

  assign r_o = r_q[Bits];

endmodule
